// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== hdl/srl_pkg.sv =====
// Shared types, constants and functions for the reverberation level block.
// No dependencies.
package srl_pkg;

	localparam int NLANE = 4;
	localparam int LANE_W = 59;
	localparam int MANT_W = 32;
	localparam int LG_W = 22;
	localparam int FRAC_W = 16;
	localparam int DB_W = 16;
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 22;

	// lane assignment
	localparam int LN_R = 0;
	localparam int LN_X = 1;
	localparam int LN_Y2 = 2;
	localparam int LN_SUM = 3;

	// register indexes
	localparam logic [CFG_AW-1:0] REG_SOUND_SPEED = 3'd0;
	localparam logic [CFG_AW-1:0] REG_PULSE_LENGTH = 3'd1;
	localparam logic [CFG_AW-1:0] REG_BEAM_GAIN = 3'd2;
	localparam logic [CFG_AW-1:0] REG_VOLUME_STR = 3'd3;
	localparam logic [CFG_AW-1:0] REG_SURFACE_STR = 3'd4;
	localparam logic [CFG_AW-1:0] REG_BOTTOM_STR = 3'd5;
	localparam logic [CFG_AW-1:0] REG_SOURCE_DEPTH = 3'd6;
	localparam logic [CFG_AW-1:0] REG_BOTTOM_DEPTH = 3'd7;

	// reverberation types
	localparam logic [1:0] CMD_VOLUME = 2'd0;
	localparam logic [1:0] CMD_SURFACE = 2'd1;
	localparam logic [1:0] CMD_BOTTOM = 2'd2;
	localparam logic [1:0] CMD_INVALID = 2'd3;

	// grazing term selection
	localparam logic [1:0] GM_NONE = 2'd0;
	localparam logic [1:0] GM_45 = 2'd1;
	localparam logic [1:0] GM_FLOOR = 2'd2;
	localparam logic [1:0] GM_CALC = 2'd3;

	localparam logic [25:0] DB_PER_LOG2 = 26'd50504453;
	localparam logic signed [20:0] PULSE_NORM_DB = 21'sd25378;
	localparam logic signed [20:0] ZERO_AREA_DB = -21'sd76800;
	localparam logic signed [20:0] GRAZE_FLOOR_DB = -21'sd10240;
	localparam logic signed [20:0] GRAZE_45_DB = -21'sd771;
	localparam logic signed [18:0] SENTINEL_DB = -19'sd255744;
	localparam logic signed [20:0] LEVEL_MAX = 21'sd262143;
	localparam logic signed [20:0] LEVEL_MIN = -21'sd262144;

	typedef logic [NLANE-1:0][MANT_W-1:0] mant_vec_t;
	typedef logic [NLANE-1:0][LG_W-1:0] lg_vec_t;

	typedef struct packed {
		logic err;
		logic sentinel;
		logic xzero;
		logic [1:0] cmd;
		logic [1:0] gmode;
	} ctl_t;

	// index of the top set bit, zero for a zero word
	function automatic logic [5:0] msb_pos(input logic [LANE_W-1:0] v);
		logic [5:0] p;
		p = '0;
		for (int i = 0; i < LANE_W; i++) begin
			if (v[i]) p = 6'(i);
		end
		return p;
	endfunction

endpackage

// ===== hdl/sonar_reverberation_level.sv =====
// Top level of the reverberation level block: register file, input products,
// normalization, chain of log2 cells, dB conversion and output register.
// Depends on srl_pkg and srl_log_cell.
//
// Usage:
//  Input requests arrive on s_tvalid/s_tready: s_tuser carries the
//  reverberation type, s_tdata the signed Q8 slant range. Each request
//  gives exactly one result on m_tvalid/m_tready: m_tuser is the error
//  status, m_tdata the Q8 dB level relative to the source.
//  From accepted request to m_tvalid a request passes one product
//  stage, one wide product stage, leading-one search, normalize shift,
//  sixteen log2 cells (one fraction bit each), dB scaling and the output
//  register. Throughput is one request per cycle unless the receiver
//  stalls; the row of squaring cells is fully pipelined.
//  When the receiver stalls, the whole pipeline holds and s_tready drops
//  in the same cycle; the pending result stays on m_tdata unchanged.
//  Reset clears all valid flags and loads the register defaults.
//  Write configuration only while no request is in flight.
module sonar_reverberation_level import srl_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_AW-1:0] cfg_addr,
	input logic [CFG_DW-1:0] cfg_wdata,
	input logic s_tvalid,
	output logic s_tready,
	input logic [31:0] s_tdata, // [24:0] range_m, rest zero
	input logic [1:0] s_tuser, // [1:0] cmd
	output logic m_tvalid,
	input logic m_tready,
	output logic [23:0] m_tdata, // [18:0] level_db, rest zero
	output logic m_tuser // [0] status
);

	localparam int NCELL = FRAC_W;

	// configuration registers
	logic [14:0] sound_speed_q;
	logic [19:0] pulse_length_q;
	logic signed [14:0] beam_gain_q;
	logic signed [15:0] volume_str_q;
	logic signed [15:0] surface_str_q;
	logic signed [15:0] bottom_str_q;
	logic [21:0] source_depth_q;
	logic [21:0] bottom_depth_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sound_speed_q <= 15'd24000;
			pulse_length_q <= 20'd1000;
			beam_gain_q <= -15'sd5120;
			volume_str_q <= -16'sd17920;
			surface_str_q <= -16'sd10240;
			bottom_str_q <= -16'sd6912;
			source_depth_q <= 22'd2560;
			bottom_depth_q <= 22'd256000;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_SOUND_SPEED: sound_speed_q <= cfg_wdata[14:0];
				REG_PULSE_LENGTH: pulse_length_q <= cfg_wdata[19:0];
				REG_BEAM_GAIN: beam_gain_q <= cfg_wdata[14:0];
				REG_VOLUME_STR: volume_str_q <= cfg_wdata[15:0];
				REG_SURFACE_STR: surface_str_q <= cfg_wdata[15:0];
				REG_BOTTOM_STR: bottom_str_q <= cfg_wdata[15:0];
				REG_SOURCE_DEPTH: source_depth_q <= cfg_wdata;
				REG_BOTTOM_DEPTH: bottom_depth_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// the whole pipeline advances together unless the output is stuck
	logic en;
	assign en = !m_tvalid || m_tready;
	assign s_tready = en;

	// stage 1: classify the request and form the narrow products
	logic [1:0] cmd_in;
	logic signed [24:0] range_in;
	logic [23:0] r_in;
	logic [21:0] y_d;
	ctl_t ctl_in;

	assign cmd_in = s_tuser;
	assign range_in = s_tdata[24:0];
	assign r_in = range_in[23:0];
	assign y_d = bottom_depth_q - source_depth_q;

	always_comb begin
		ctl_in.err = range_in[24] || (cmd_in == CMD_INVALID);
		ctl_in.sentinel = (r_in[23:8] == '0);
		ctl_in.xzero = (sound_speed_q == '0) || (pulse_length_q == '0);
		ctl_in.cmd = cmd_in;
		if (cmd_in != CMD_BOTTOM) begin
			ctl_in.gmode = GM_NONE;
		end else if (r_in <= {2'b0, bottom_depth_q}) begin
			ctl_in.gmode = GM_45;
		end else if (bottom_depth_q <= source_depth_q) begin
			ctl_in.gmode = GM_FLOOR;
		end else begin
			ctl_in.gmode = GM_CALC;
		end
	end

	logic v_s1;
	ctl_t ctl_s1;
	logic [23:0] r_s1;
	logic [34:0] cp_s1;
	logic [47:0] rr_s1;
	logic [43:0] y2_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1 <= ctl_in;
			r_s1 <= r_in;
			cp_s1 <= 35'(sound_speed_q) * 35'(pulse_length_q);
			rr_s1 <= 48'(r_in) * 48'(r_in);
			y2_s1 <= 44'(y_d) * 44'(y_d);
		end
	end

	// stage 2: wide area product and the hypotenuse sum
	logic v_s2;
	ctl_t ctl_s2;
	logic [NLANE-1:0][LANE_W-1:0] lane_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s2 <= ctl_s1;
			lane_s2[LN_R] <= LANE_W'(r_s1);
			lane_s2[LN_X] <= LANE_W'(cp_s1) * LANE_W'(r_s1);
			lane_s2[LN_Y2] <= LANE_W'(y2_s1);
			lane_s2[LN_SUM] <= LANE_W'(rr_s1) + LANE_W'(y2_s1);
		end
	end

	// stage 3: locate the top set bit of every lane
	logic v_s3;
	ctl_t ctl_s3;
	logic [NLANE-1:0][LANE_W-1:0] lane_s3;
	logic [NLANE-1:0][5:0] n_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s3 <= ctl_s2;
			lane_s3 <= lane_s2;
			for (int i = 0; i < NLANE; i++) n_s3[i] <= msb_pos(lane_s2[i]);
		end
	end

	// stage 4: shift the top bit to bit 31 of the mantissa
	logic [NLANE-1:0][63:0] shl;
	always_comb begin
		for (int i = 0; i < NLANE; i++) begin
			shl[i] = {5'b0, lane_s3[i]} << (6'd63 - n_s3[i]);
		end
	end

	logic v_s4;
	ctl_t ctl_s4;
	mant_vec_t m_s4;
	lg_vec_t res_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s4 <= ctl_s3;
			for (int i = 0; i < NLANE; i++) begin
				m_s4[i] <= shl[i][63:32];
				res_s4[i] <= {n_s3[i], {FRAC_W{1'b0}}};
			end
		end
	end

	logic valid_c [1:NCELL];
	ctl_t ctl_c [1:NCELL];
	mant_vec_t m_c [1:NCELL];
	lg_vec_t res_c [1:NCELL];

	// chain of squaring cells, most significant fraction bit first
	for (genvar k = 0; k < NCELL; k++) begin : g_cell
		logic v_i;
		ctl_t ctl_i;
		mant_vec_t m_i;
		lg_vec_t res_i;

		if (k == 0) begin : g_head
			assign v_i = v_s4;
			assign ctl_i = ctl_s4;
			assign m_i = m_s4;
			assign res_i = res_s4;
		end else begin : g_link
			assign v_i = valid_c[k];
			assign ctl_i = ctl_c[k];
			assign m_i = m_c[k];
			assign res_i = res_c[k];
		end

		srl_log_cell #(
			.BIT(NCELL - 1 - k)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.valid_in(v_i),
			.ctl_in(ctl_i),
			.m_in(m_i),
			.res_in(res_i),
			.valid_out(valid_c[k+1]),
			.ctl_out(ctl_c[k+1]),
			.m_out(m_c[k+1]),
			.res_out(res_c[k+1])
		);
	end

	// dB scaling stage: 10*log10(2) in Q24, rounded
	lg_vec_t lg_in;
	logic [NLANE-1:0][47:0] dbp;
	always_comb begin
		lg_in = res_c[NCELL];
		lg_in[LN_R] = res_c[NCELL][LN_R] - LG_W'(8 << FRAC_W);
		for (int i = 0; i < NLANE; i++) begin
			dbp[i] = 48'(lg_in[i]) * 48'(DB_PER_LOG2) + 48'h0000_8000_0000;
		end
	end

	logic v_s21;
	ctl_t ctl_s21;
	logic [NLANE-1:0][DB_W-1:0] d_s21;

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s21 <= ctl_c[NCELL];
			for (int i = 0; i < NLANE; i++) d_s21[i] <= dbp[i][47:32];
		end
	end

	// final sum and saturation
	logic signed [20:0] d0, d1, d2, d3;
	logic signed [20:0] strength, area, graze, gcalc, level;
	logic signed [18:0] level_sat;

	always_comb begin
		d0 = 21'(d_s21[LN_R]);
		d1 = 21'(d_s21[LN_X]);
		d2 = 21'(d_s21[LN_Y2]);
		d3 = 21'(d_s21[LN_SUM]);
		case (ctl_s21.cmd)
			CMD_VOLUME: strength = 21'(volume_str_q);
			CMD_SURFACE: strength = 21'(surface_str_q);
			default: strength = 21'(bottom_str_q);
		endcase
		area = ctl_s21.xzero ? ZERO_AREA_DB : d1 - PULSE_NORM_DB + 21'(beam_gain_q);
		gcalc = d2 - d3;
		case (ctl_s21.gmode)
			GM_NONE: graze = '0;
			GM_45: graze = GRAZE_45_DB;
			GM_FLOOR: graze = GRAZE_FLOOR_DB;
			default: graze = (gcalc < GRAZE_FLOOR_DB) ? GRAZE_FLOOR_DB : gcalc;
		endcase
		level = strength + area + graze - (d0 <<< 2);
		if (level > LEVEL_MAX) level_sat = LEVEL_MAX[18:0];
		else if (level < LEVEL_MIN) level_sat = LEVEL_MIN[18:0];
		else level_sat = level[18:0];
	end

	// output register; hold while the receiver stalls
	always_ff @(posedge clk) begin
		if (en) begin
			if (ctl_s21.err) begin
				m_tuser <= 1'b1;
				m_tdata <= '0;
			end else if (ctl_s21.sentinel) begin
				m_tuser <= 1'b0;
				m_tdata <= {5'b0, SENTINEL_DB};
			end else begin
				m_tuser <= 1'b0;
				m_tdata <= {5'b0, level_sat};
			end
		end
	end

	// valid flags of the stages around the cell chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s21 <= 1'b0;
			m_tvalid <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s21 <= valid_c[NCELL];
			m_tvalid <= v_s21;
		end
	end

endmodule

// ===== hdl/srl_log_cell.sv =====
// One fraction-bit step of the log2 chain: square the mantissa of every lane.
// Depends on srl_pkg.
module srl_log_cell import srl_pkg::*; #(
	parameter int BIT = 15
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic valid_in,
	input ctl_t ctl_in,
	input mant_vec_t m_in,
	input lg_vec_t res_in,
	output logic valid_out,
	output ctl_t ctl_out,
	output mant_vec_t m_out,
	output lg_vec_t res_out
);

	logic [NLANE-1:0][2*MANT_W-1:0] sq;
	lg_vec_t res_nx;

	// a square of two or more sets this cell's fraction bit
	always_comb begin
		for (int i = 0; i < NLANE; i++) begin
			sq[i] = m_in[i] * m_in[i];
			res_nx[i] = res_in[i];
			res_nx[i][BIT] = res_in[i][BIT] | sq[i][2*MANT_W-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else if (en) begin
			valid_out <= valid_in;
		end
	end

	// renormalize: keep the mantissa in [1,2) and emit the bit
	always_ff @(posedge clk) begin
		if (en) begin
			ctl_out <= ctl_in;
			res_out <= res_nx;
			for (int i = 0; i < NLANE; i++) begin
				if (sq[i][2*MANT_W-1]) begin
					m_out[i] <= sq[i][2*MANT_W-1:MANT_W];
				end else begin
					m_out[i] <= sq[i][2*MANT_W-2:MANT_W-1];
				end
			end
		end
	end

endmodule

// ===== hdl/srl_checker.sv =====
// Port-level checker for the reverberation level block, bound to the top.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module srl_checker (
	input logic clk,
	input logic arst_n,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [23:0] m_tdata,
	input logic m_tuser
);

	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	`ASSERT_NEXT(a_out_stable, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser))
	`ASSERT_HOLDS(a_ready_follows_out, clk, arst_n, s_tready == (!m_tvalid || m_tready))
	`ASSERT_HOLDS(a_err_zero_level, clk, arst_n, !(m_tvalid && m_tuser) || (m_tdata == '0))
	`ASSERT_HOLDS(a_pad_zero, clk, arst_n, !m_tvalid || (m_tdata[23:19] == '0))

endmodule

bind sonar_reverberation_level srl_checker u_srl_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata),
	.m_tuser(m_tuser)
);

// ===== dv/tb_sonar_reverberation_level.sv =====
// Self-checking testbench for sonar_reverberation_level: directed and random
// range requests under several register settings, checked against a local model.
// Depends on srl_pkg and the sonar_reverberation_level RTL.
`timescale 1ns / 100ps

module tb_sonar_reverberation_level;
	import srl_pkg::*;

	localparam int PIPE_LAT = 22;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RAND_PER_PHASE = 90;

	typedef struct {
		logic [1:0] cmd;
		logic signed [24:0] range_q8;
	} range_req_t;

	typedef struct {
		logic status;
		logic signed [18:0] level;
	} level_res_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_AW-1:0] cfg_addr;
	logic [CFG_DW-1:0] cfg_wdata;
	logic s_tvalid;
	logic s_tready;
	logic [31:0] s_tdata;
	logic [1:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [23:0] m_tdata;
	logic m_tuser;

	sonar_reverberation_level uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	// Register shadow copy, kept in step with every write.
	longint unsigned ss_reg, pl_reg, srcd_reg, botd_reg;
	longint beam_reg, vol_reg, surf_reg, bot_reg;

	range_req_t pending_reqs[$];
	level_res_t expected_levels[$];

	int n_sent, n_recv, n_errs, n_phases;
	int cycles;
	int gap_cnt, stall_cnt;
	bit send_burst, recv_burst;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// log2 of x in Q16: top bit index, then sixteen squarings of a Q31 mantissa.
	function automatic longint unsigned log2_q16(input longint unsigned x);
		int n;
		longint unsigned m, res;
		if (x == 0) begin
			return 0;
		end
		n = 63;
		while (x[n] == 1'b0) begin
			n--;
		end
		m = (n >= 31) ? (x >> (n - 31)) : (x << (31 - n));
		res = longint'(n) << 16;
		for (int i = 15; i >= 0; i--) begin
			m = (m * m) >> 31;
			if ((m >> 32) != 0) begin
				m = m >> 1;
				res |= 64'd1 << i;
			end
		end
		return res;
	endfunction

	function automatic longint db_q8(input longint unsigned l2);
		return longint'((l2 * 64'd50504453 + 64'h8000_0000) >> 32);
	endfunction

	function automatic level_res_t level_predict(input range_req_t rq);
		level_res_t o;
		longint unsigned r, x, y, y2;
		longint strength, area, graze, lvl;
		o.status = 1'b0;
		o.level = '0;
		// negative range or bad type: error flag, zero level
		if (rq.range_q8 < 0 || rq.cmd == CMD_INVALID) begin
			o.status = 1'b1;
			return o;
		end
		// under one metre: fixed -999 dB marker
		if (rq.range_q8 < 256) begin
			o.level = SENTINEL_DB;
			return o;
		end
		r = longint'(rq.range_q8);
		graze = 0;
		case (rq.cmd)
			CMD_VOLUME: strength = vol_reg;
			CMD_SURFACE: strength = surf_reg;
			default: strength = bot_reg;
		endcase
		x = ss_reg * pl_reg * r;
		// a zero product replaces the whole area term, beam gain included
		if (x == 0) begin
			area = -76800;
		end else begin
			area = db_q8(log2_q16(x)) - 25378 + beam_reg;
		end
		if (rq.cmd == CMD_BOTTOM) begin
			if (r > botd_reg) begin
				// source at or below the seafloor: floor angle
				if (botd_reg <= srcd_reg) begin
					graze = -10240;
				end else begin
					y = botd_reg - srcd_reg;
					y2 = y * y;
					graze = db_q8(log2_q16(y2)) - db_q8(log2_q16(r * r + y2));
					if (graze < -10240) begin
						graze = -10240;
					end
				end
			end else begin
				graze = -771;
			end
		end
		lvl = -4 * db_q8(log2_q16(r) - (64'd8 << 16)) + strength + area + graze;
		if (lvl > 262143) begin
			lvl = 262143;
		end
		if (lvl < -262144) begin
			lvl = -262144;
		end
		o.level = 19'(lvl);
		return o;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("[%0t] MISMATCH %s: got %0d, want %0d (result %0d)", $time, what, got, want,
			n_recv);
		n_errs++;
	endtask

	function automatic int draw_gap(input bit burst);
		return burst ? 0 : int'($urandom_range(0, 13));
	endfunction

	// Driver: present requests from the pending queue, hold while s_tready is low,
	// and record the expected level of each accepted request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			gap_cnt <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				range_req_t acc;
				acc.cmd = s_tuser;
				acc.range_q8 = s_tdata[24:0];
				expected_levels.push_back(level_predict(acc));
				n_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_cnt > 0) begin
					gap_cnt <= gap_cnt - 1;
					s_tvalid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					range_req_t nx;
					nx = pending_reqs.pop_front();
					s_tdata <= {7'd0, nx.range_q8};
					s_tuser <= nx.cmd;
					s_tvalid <= 1'b1;
					if ($urandom_range(0, 19) == 0) begin
						send_burst = ~send_burst;
					end
					gap_cnt <= draw_gap(send_burst);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each accepted result with the oldest expectation, then
	// draw how long to stall before taking the next one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_cnt <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				int st;
				n_recv++;
				if (expected_levels.size() == 0) begin
					report_mismatch("unexpected result, level", $signed(m_tdata[18:0]), 0);
				end else begin
					level_res_t want;
					want = expected_levels.pop_front();
					if (m_tuser !== want.status) begin
						report_mismatch("status", m_tuser, want.status);
					end
					if (m_tdata[18:0] !== want.level) begin
						report_mismatch("level_db", $signed(m_tdata[18:0]), want.level);
					end
				end
				if ($urandom_range(0, 19) == 0) begin
					recv_burst = ~recv_burst;
				end
				st = draw_gap(recv_burst);
				stall_cnt <= st;
				m_tready <= (st == 0);
			end else if (stall_cnt > 0) begin
				stall_cnt <= stall_cnt - 1;
				m_tready <= (stall_cnt == 1);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding", cycles,
				expected_levels.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Write all eight registers on back-to-back cycles; mirror them in the shadow copy.
	task automatic load_regs(input longint unsigned ss, input longint unsigned pl,
		input longint beam, input longint vol, input longint surf, input longint bot,
		input longint unsigned srcd, input longint unsigned botd);
		logic [CFG_DW-1:0] vals[8];
		vals[REG_SOUND_SPEED] = CFG_DW'(ss);
		vals[REG_PULSE_LENGTH] = CFG_DW'(pl);
		vals[REG_BEAM_GAIN] = CFG_DW'(beam) & 22'h7FFF;
		vals[REG_VOLUME_STR] = CFG_DW'(vol) & 22'hFFFF;
		vals[REG_SURFACE_STR] = CFG_DW'(surf) & 22'hFFFF;
		vals[REG_BOTTOM_STR] = CFG_DW'(bot) & 22'hFFFF;
		vals[REG_SOURCE_DEPTH] = CFG_DW'(srcd);
		vals[REG_BOTTOM_DEPTH] = CFG_DW'(botd);
		for (int i = 0; i < 8; i++) begin
			@(posedge clk);
			cfg_we <= 1'b1;
			cfg_addr <= CFG_AW'(i);
			cfg_wdata <= vals[i];
		end
		@(posedge clk);
		cfg_we <= 1'b0;
		ss_reg = ss;
		pl_reg = pl;
		beam_reg = beam;
		vol_reg = vol;
		surf_reg = surf;
		bot_reg = bot;
		srcd_reg = srcd;
		botd_reg = botd;
	endtask

	task automatic add_req(input logic [1:0] cmd, input longint rng);
		range_req_t rq;
		rq.cmd = cmd;
		rq.range_q8 = 25'(rng);
		pending_reqs.push_back(rq);
	endtask

	// Mostly valid types and positive ranges of random magnitude, some noise.
	task automatic add_random(input int n);
		for (int i = 0; i < n; i++) begin
			int w;
			logic [1:0] c;
			longint v;
			c = ($urandom_range(0, 9) == 0) ? CMD_INVALID : 2'($urandom_range(0, 2));
			w = $urandom_range(6, 24);
			v = longint'($urandom & ((32'd1 << w) - 1));
			if ($urandom_range(0, 9) == 0) begin
				v = -longint'($urandom_range(1, 16777216));
			end
			add_req(c, v);
		end
	endtask

	// Wait for every request to be accepted and answered, then let the pipe drain.
	// Sample on the falling edge so the driver's updates of the same edge are seen.
	task automatic drain;
		@(negedge clk);
		while (pending_reqs.size() > 0 || s_tvalid || expected_levels.size() > 0) begin
			@(negedge clk);
		end
		repeat (PIPE_LAT + 8) @(posedge clk);
		n_phases++;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		n_sent = 0;
		n_recv = 0;
		n_errs = 0;
		n_phases = 0;
		cycles = 0;
		send_burst = 1'b0;
		recv_burst = 1'b0;
		ss_reg = 24000;
		pl_reg = 1000;
		beam_reg = -5120;
		vol_reg = -17920;
		surf_reg = -10240;
		bot_reg = -6912;
		srcd_reg = 2560;
		botd_reg = 256000;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes, each type, sub-metre, bottom edge, errors.
		add_req(CMD_VOLUME, 0);
		add_req(CMD_SURFACE, 255);
		add_req(CMD_BOTTOM, 256);
		add_req(CMD_VOLUME, 257);
		add_req(CMD_SURFACE, 16777215);
		add_req(CMD_BOTTOM, 16777215);
		add_req(CMD_VOLUME, -1);
		add_req(CMD_BOTTOM, -16777216);
		add_req(CMD_INVALID, 25600);
		add_req(CMD_INVALID, 0);
		add_req(CMD_INVALID, -1);
		add_req(CMD_BOTTOM, 256000);
		add_req(CMD_BOTTOM, 256001);
		add_req(CMD_BOTTOM, 2560);
		add_req(CMD_SURFACE, 1);
		add_req(CMD_VOLUME, 25600);
		add_req(CMD_VOLUME, 16777215);
		add_req(CMD_BOTTOM, 8388608);
		add_random(RAND_PER_PHASE);
		drain();

		// Largest values: saturation high, long pulse, deep bottom.
		load_regs(32767, 1000000, 16383, 32767, 32767, 32767, 0, 2560000);
		add_req(CMD_BOTTOM, 2560001);
		add_req(CMD_VOLUME, 16777215);
		add_random(RAND_PER_PHASE);
		drain();

		// Smallest values: zero product, source below the seafloor.
		load_regs(0, 0, -16384, -32768, -32768, -32768, 2560000, 0);
		add_req(CMD_BOTTOM, 256);
		add_random(RAND_PER_PHASE);
		drain();

		// Random settings within the register ranges.
		for (int p = 0; p < 2; p++) begin
			load_regs($urandom_range(0, 32767), $urandom_range(0, 1000000),
				longint'($urandom_range(0, 32767)) - 16384,
				longint'($urandom_range(0, 65535)) - 32768,
				longint'($urandom_range(0, 65535)) - 32768,
				longint'($urandom_range(0, 65535)) - 32768,
				$urandom_range(0, 2560000), $urandom_range(0, 2560000));
			add_random(RAND_PER_PHASE);
			drain();
		end

		$display("Covered %0d requests and %0d results over %0d register settings", n_sent,
			n_recv, n_phases);
		$display("Mismatches: %0d", n_errs);
		if (n_errs == 0 && expected_levels.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ===== sonar_reverberation_level.f =====
+incdir+hdl
hdl/srl_pkg.sv
hdl/srl_log_cell.sv
hdl/sonar_reverberation_level.sv
hdl/srl_checker.sv
dv/tb_sonar_reverberation_level.sv
